[hdl/bar_pkg.sv]
package bar_pkg;

    localparam int LEN_W           = 13;
    localparam int MAX_LINE        = 4096;
    localparam int POS_W           = 12;
    localparam int PIX_W           = 16;
    localparam int RESULT_LIMIT    = 64;
    localparam int RES_CNT_W       = 7;
    localparam int WINDOW_TAPS_DEF = 64;

    // serial divider geometry
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 30;
    localparam int DIV_QW = 29;
    localparam int REM_W  = 31;
    localparam int Q_WIDE = 29;
    localparam int Q_TAP  = 19;
    localparam int Q_NORM = 16;

    localparam int FS_W  = 29;
    localparam int U_W   = 19;
    localparam int WT_W  = 16;
    localparam int IDX_W = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd2;

    typedef enum logic [1:0] {
        DIV_WIDE,
        DIV_TAP,
        DIV_NORM
    } div_mode_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] red_in;
        logic signed [PIX_W-1:0] green_in;
        logic signed [PIX_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] red_out;
        logic signed [PIX_W-1:0] green_out;
        logic signed [PIX_W-1:0] blue_out;
        logic [POS_W-1:0]        out_position;
        logic                    line_end;
        logic                    frame_end;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FS_START,
        ST_FS_WAIT,
        ST_CHECK,
        ST_CEN_WAIT,
        ST_BOUNDS,
        ST_TAP,
        ST_TAP_WAIT,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_ACC,
        ST_NORM,
        ST_NORM_WAIT,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic div_fs;
        logic ld_fs;
        logic div_cen;
        logic ld_cen;
        logic skip;
        logic open_out;
        logic div_tap;
        logic ld_u;
        logic acc;
        logic div_norm;
        logic ld_chan;
        logic emit;
        logic wrap_up;
    } cmd_t;

    typedef struct packed {
        logic reduce;
        logic div_done;
        logic out_done;
        logic hi_late;
        logic limit;
        logic taps_left;
        logic last_chan;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

[hdl/bar_stream_if.sv]
interface bar_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/bicubic_antialias_resampler.sv]
// One-axis RGB bicubic resampler (a = -0.5) with antialiasing on reduction.
// Pixels of a line enter one beat at a time into a window of WINDOW_TAPS
// entries; each output is produced once its last tap has arrived, carrying
// its index, line_end and frame_end. One input beat is taken at a time.
// Every division (scale, output centre, tap argument, normalization) runs
// on one shared restoring divider at one bit a cycle. The scale is divided
// only when reducing; each output has its centre divided, then each tap
// a divide followed by the kernel and multiply-accumulate, and lastly the
// three channels are normalized one after another before it is emitted.
module bicubic_antialias_resampler #(
    parameter int WINDOW_TAPS = bar_pkg::WINDOW_TAPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bar_stream_if.sink                     pixels,
    bar_stream_if.source                   results,
    input  logic                           cfg_write,
    input  logic [bar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bar_pkg::LEN_W-1:0]      cfg_data
);

    bar_pkg::cmd_t  cmd;
    bar_pkg::stat_t stat;
    logic           in_ready;

    assign pixels.ready = in_ready;

    bar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bar_datapath #(
        .WINDOW_TAPS (WINDOW_TAPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pix_in    (pixels.payload),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (results.valid),
        .res_data  (results.payload),
        .res_ready (results.ready)
    );

endmodule

[hdl/bar_divider.sv]
module bar_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  bar_pkg::div_mode_t          mode,
    input  logic [bar_pkg::DIV_NW-1:0]  num,
    input  logic [bar_pkg::DIV_DW-1:0]  den,
    output logic                        done,
    output logic [bar_pkg::DIV_QW-1:0]  quo
);

    logic [bar_pkg::REM_W-1:0]  rem_reg;
    logic [bar_pkg::DIV_QW-1:0] sh_reg;
    logic [bar_pkg::DIV_QW-1:0] quo_reg;
    logic [bar_pkg::DIV_DW-1:0] den_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [bar_pkg::REM_W:0]    trial;

    assign trial = {rem_reg, sh_reg[bar_pkg::DIV_QW-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                case (mode)
                    bar_pkg::DIV_TAP:  cnt_reg <= 5'(bar_pkg::Q_TAP);
                    bar_pkg::DIV_NORM: cnt_reg <= 5'(bar_pkg::Q_NORM);
                    default:           cnt_reg <= 5'(bar_pkg::Q_WIDE);
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            quo_reg <= '0;
            case (mode)
                bar_pkg::DIV_TAP:
                begin
                    rem_reg <= 31'(num >> bar_pkg::Q_TAP);
                    sh_reg  <= {num[bar_pkg::Q_TAP-1:0], 10'b0};
                end
                bar_pkg::DIV_NORM:
                begin
                    rem_reg <= 31'(num >> bar_pkg::Q_NORM);
                    sh_reg  <= {num[bar_pkg::Q_NORM-1:0], 13'b0};
                end
                default:
                begin
                    rem_reg <= 31'(num >> bar_pkg::Q_WIDE);
                    sh_reg  <= num[bar_pkg::Q_WIDE-1:0];
                end
            endcase
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[bar_pkg::DIV_QW-2:0], 1'b0};
            if (!trial[bar_pkg::REM_W])
                rem_reg <= trial[bar_pkg::REM_W-1:0];
            else
                rem_reg <= {rem_reg[bar_pkg::REM_W-2:0], sh_reg[bar_pkg::DIV_QW-1]};
            quo_reg <= {quo_reg[bar_pkg::DIV_QW-2:0], ~trial[bar_pkg::REM_W]};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hdl/bar_datapath.sv]
module bar_datapath #(
    parameter int WINDOW_TAPS = bar_pkg::WINDOW_TAPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bar_pkg::cmd_t                  cmd,
    output bar_pkg::stat_t                 stat,
    input  bar_pkg::pixel_t                pix_in,
    input  logic                           cfg_write,
    input  logic [bar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bar_pkg::LEN_W-1:0]      cfg_data,
    output logic                           res_valid,
    output bar_pkg::result_t               res_data,
    input  logic                           res_ready
);

    localparam int AB     = $clog2(WINDOW_TAPS);
    localparam int ACC_W  = 33 + AB;
    localparam int WS_W   = 16 + AB;
    localparam int NN_W   = ACC_W + 1;
    localparam int LW     = bar_pkg::LEN_W;
    localparam int IW     = bar_pkg::IDX_W;

    function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v);
        logic [LW-1:0] r;
        r = v;
        if (v == '0)
            r = LW'(1);
        else if (v > LW'(bar_pkg::MAX_LINE))
            r = LW'(bar_pkg::MAX_LINE);
        return r;
    endfunction

    // configuration
    logic [LW-1:0] in_len_reg, out_len_reg, line_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg   <= LW'(1);
            out_len_reg  <= LW'(1);
            line_cfg_reg <= LW'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bar_pkg::REG_IN_LENGTH:  in_len_reg   <= clamp_len(cfg_data);
                bar_pkg::REG_OUT_LENGTH: out_len_reg  <= clamp_len(cfg_data);
                bar_pkg::REG_LINE_COUNT: line_cfg_reg <= clamp_len(cfg_data);
                default: ;
            endcase
        end
    end

    // counters
    logic [LW-1:0]                   in_cnt_reg, out_cnt_reg;
    logic [bar_pkg::POS_W-1:0]       line_cnt_reg;
    logic [AB-1:0]                   wp_reg;
    logic [bar_pkg::RES_CNT_W-1:0]   res_cnt_reg;
    logic [1:0]                      chan_reg;

    logic line_last, frame_last;
    assign line_last  = (in_cnt_reg + LW'(1)) >= in_len_reg;
    assign frame_last = ({1'b0, line_cnt_reg} + LW'(1)) >= line_cfg_reg;

    // window store
    bar_pkg::pixel_t win_mem [WINDOW_TAPS];
    bar_pkg::pixel_t rd_reg;
    logic [AB-1:0]   rd_addr;

    // position registers
    logic [bar_pkg::FS_W-1:0] fs_reg, centre_reg;
    logic [IW-1:0]            k_reg, hi_reg;

    // divider
    logic                         div_start, div_done;
    bar_pkg::div_mode_t           div_mode;
    logic [bar_pkg::DIV_NW-1:0]   div_num;
    logic [bar_pkg::DIV_DW-1:0]   div_den;
    logic [bar_pkg::DIV_QW-1:0]   div_quo;

    bar_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mode  (div_mode),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // bounds of the current output
    logic [26:0]        cen_prod;
    logic signed [31:0] lraw;
    logic [31:0]        hraw;
    logic [IW-1:0]      lo_idx, hi_raw, hi_idx, start_idx;
    logic signed [17:0] oldest;

    always_comb
    begin
        cen_prod = 27'({out_cnt_reg, 1'b1}) * 27'(in_len_reg);
        lraw = $signed({3'b0, centre_reg}) - $signed({2'b0, fs_reg, 1'b0}) + 32'sd32768;
        lo_idx = lraw[31] ? '0 : lraw[31:16];
        hraw = {3'b0, centre_reg} + {2'b0, fs_reg, 1'b0} + 32'd32768;
        hi_raw = hraw[31:16];
        hi_idx = (hi_raw > IW'(in_len_reg)) ? IW'(in_len_reg) : hi_raw;
        oldest = $signed({5'b0, in_cnt_reg}) + 18'sd1 - 18'(WINDOW_TAPS);
        start_idx = (oldest > $signed({2'b0, lo_idx})) ? oldest[IW-1:0] : lo_idx;
    end

    // tap argument and window address
    logic signed [33:0] diff;
    logic [29:0]        tap_ad;
    logic [AB:0]        tap_back;

    always_comb
    begin
        diff = $signed({1'b0, k_reg, 1'b1, 15'b0}) - $signed({5'b0, centre_reg});
        tap_ad = diff[33] ? 30'(-diff) : 30'(diff);
        tap_back = (AB+1)'(in_cnt_reg - k_reg[LW-1:0]);
        if ({1'b0, wp_reg} >= tap_back)
            rd_addr = AB'({1'b0, wp_reg} - tap_back);
        else
            rd_addr = AB'({1'b0, wp_reg} + (AB+1)'(WINDOW_TAPS) - tap_back);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            win_mem[wp_reg] <= pix_in;
        if (cmd.div_tap)
            rd_reg <= win_mem[rd_addr];
    end

    // cubic kernel, registered stages m1, p2, lo and w, at most one variable multiply each
    logic [bar_pkg::U_W-1:0] u_reg;
    logic signed [19:0]      u_s;
    logic signed [21:0]      f_s;
    logic signed [41:0]      m1_reg, p2_reg;
    logic [37:0]             lo_reg;
    logic signed [22:0]      p2_hi;
    logic signed [42:0]      hprod;
    logic signed [61:0]      n_sum;
    logic signed [bar_pkg::WT_W-1:0] w_reg;
    logic near, big;

    always_comb
    begin
        u_s   = $signed({1'b0, u_reg});
        near  = u_reg <= 19'd65536;
        big   = u_reg[18:17] != 2'b00;
        f_s   = near ? (22'(u_s) * 22'd3 - 22'sd327680) : (22'sd327680 - 22'(u_s));
        p2_hi = p2_reg[41:19];
        hprod = u_s * p2_hi;
        n_sum = $signed({hprod, 19'b0}) + $signed({24'b0, lo_reg})
              + (near ? 62'sd562949953421312 : 62'sd1125899906842624)
              + 62'sd17179869184;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_u)
            u_reg <= div_quo[bar_pkg::U_W-1:0];
        m1_reg <= u_s * f_s;
        p2_reg <= m1_reg + (near ? 42'sd0 : -42'sd34359738368);
        lo_reg <= u_reg * p2_reg[18:0];
        w_reg  <= big ? '0 : n_sum[50:35];
    end

    // accumulation
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [WS_W-1:0]  wsum_reg;
    logic signed [bar_pkg::PIX_W-1:0] px_ch [3];
    logic signed [31:0] prod [3];

    always_comb
    begin
        px_ch[0] = rd_reg.red_in;
        px_ch[1] = rd_reg.green_in;
        px_ch[2] = rd_reg.blue_in;
        for (int c = 0; c < 3; c++)
            prod[c] = w_reg * px_ch[c];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.open_out)
        begin
            wsum_reg <= '0;
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= '0;
        end
        else if (cmd.acc)
        begin
            wsum_reg <= wsum_reg + WS_W'(w_reg);
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= acc_reg[c] + ACC_W'(prod[c]);
        end
    end

    // normalization
    logic signed [WS_W-1:0]  den_s;
    logic signed [ACC_W-1:0] acc_sel;
    logic [ACC_W-1:0]        an;
    logic [WS_W-1:0]         adn;
    logic [NN_W-1:0]         norm_num;
    logic [WS_W:0]           norm_den;
    logic                    ovf, neg;
    logic [15:0]             q16;
    logic signed [bar_pkg::PIX_W-1:0] sat_val;
    logic signed [bar_pkg::PIX_W-1:0] res_ch_reg [3];

    always_comb
    begin
        den_s = (wsum_reg == '0) ? WS_W'(16384) : wsum_reg;
        case (chan_reg)
            2'd1:    acc_sel = acc_reg[1];
            2'd2:    acc_sel = acc_reg[2];
            default: acc_sel = acc_reg[0];
        endcase
        an = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
        adn = den_s[WS_W-1] ? WS_W'(-den_s) : WS_W'(den_s);
        norm_num = {an, 1'b0} + NN_W'(adn);
        norm_den = {adn, 1'b0};
        ovf = (norm_num >> 16) >= NN_W'(norm_den);
        neg = acc_sel[ACC_W-1] ^ den_s[WS_W-1];
        q16 = div_quo[15:0];
        if (neg)
            sat_val = (ovf || q16 > 16'd32768) ? 16'sh8000 : 16'(17'd0 - {1'b0, q16});
        else
            sat_val = (ovf || q16 > 16'd32767) ? 16'sh7fff : q16;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_chan)
            res_ch_reg[chan_reg] <= sat_val;
    end

    always_comb
    begin
        div_start = cmd.div_fs | cmd.div_cen | cmd.div_tap | cmd.div_norm;
        div_mode  = bar_pkg::DIV_WIDE;
        div_num   = bar_pkg::DIV_NW'({in_len_reg, 16'b0});
        div_den   = bar_pkg::DIV_DW'(out_len_reg);
        if (cmd.div_cen)
            div_num = bar_pkg::DIV_NW'({cen_prod, 15'b0});
        else if (cmd.div_tap)
        begin
            div_mode = bar_pkg::DIV_TAP;
            div_num  = bar_pkg::DIV_NW'({tap_ad, 16'b0});
            div_den  = bar_pkg::DIV_DW'(fs_reg);
        end
        else if (cmd.div_norm)
        begin
            div_mode = bar_pkg::DIV_NORM;
            div_num  = bar_pkg::DIV_NW'(norm_num);
            div_den  = bar_pkg::DIV_DW'(norm_den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            fs_reg <= bar_pkg::FS_W'(65536);
        else if (cmd.ld_fs)
            fs_reg <= div_quo;
        if (cmd.ld_cen)
            centre_reg <= div_quo;
        if (cmd.open_out)
        begin
            k_reg  <= start_idx;
            hi_reg <= hi_idx;
        end
        else if (cmd.acc)
            k_reg <= k_reg + IW'(1);
    end

    // pending result and output register
    bar_pkg::result_t pend_reg, out_reg;
    logic pend_valid_reg, out_valid_reg;
    bar_pkg::result_t new_res;

    always_comb
    begin
        new_res.red_out      = res_ch_reg[0];
        new_res.green_out    = res_ch_reg[1];
        new_res.blue_out     = res_ch_reg[2];
        new_res.out_position = out_cnt_reg[bar_pkg::POS_W-1:0];
        new_res.line_end     = 1'b0;
        new_res.frame_end    = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_reg <= new_res;
            if (pend_valid_reg)
                out_reg <= pend_reg;
        end
        else if (cmd.wrap_up && pend_valid_reg)
        begin
            out_reg           <= pend_reg;
            out_reg.line_end  <= line_last;
            out_reg.frame_end <= line_last && frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg     <= '0;
            out_cnt_reg    <= '0;
            line_cnt_reg   <= '0;
            wp_reg         <= '0;
            res_cnt_reg    <= '0;
            chan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((cmd.emit || cmd.wrap_up) && pend_valid_reg)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;

            if (cmd.take)
                res_cnt_reg <= '0;
            if (cmd.open_out)
                chan_reg <= '0;
            else if (cmd.ld_chan)
                chan_reg <= chan_reg + 2'd1;
            if (cmd.skip)
                out_cnt_reg <= out_cnt_reg + LW'(1);
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
                out_cnt_reg    <= out_cnt_reg + LW'(1);
                res_cnt_reg    <= res_cnt_reg + bar_pkg::RES_CNT_W'(1);
            end
            if (cmd.wrap_up)
            begin
                pend_valid_reg <= 1'b0;
                if (line_last)
                begin
                    in_cnt_reg   <= '0;
                    out_cnt_reg  <= '0;
                    wp_reg       <= '0;
                    line_cnt_reg <= frame_last ? '0 : line_cnt_reg + bar_pkg::POS_W'(1);
                end
                else
                begin
                    in_cnt_reg <= in_cnt_reg + LW'(1);
                    wp_reg     <= ({1'b0, wp_reg} == (AB+1)'(WINDOW_TAPS - 1))
                                  ? '0 : wp_reg + AB'(1);
                end
            end
        end
    end

    always_comb
    begin
        stat.reduce     = in_len_reg > out_len_reg;
        stat.div_done   = div_done;
        stat.out_done   = out_cnt_reg >= out_len_reg;
        stat.hi_late    = hi_idx > IW'(in_cnt_reg + LW'(1));
        stat.limit      = res_cnt_reg >= bar_pkg::RES_CNT_W'(bar_pkg::RESULT_LIMIT);
        stat.taps_left  = k_reg < hi_reg;
        stat.last_chan  = chan_reg == 2'd2;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || res_ready;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

[hdl/bar_ctrl.sv]
module bar_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bar_pkg::stat_t stat,
    output bar_pkg::cmd_t  cmd
);

    bar_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bar_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            bar_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = bar_pkg::ST_FS_START;
                end
            end
            bar_pkg::ST_FS_START:
            begin
                if (stat.reduce)
                begin
                    cmd.div_fs = 1'b1;
                    state_next = bar_pkg::ST_FS_WAIT;
                end
                else
                    state_next = bar_pkg::ST_CHECK;
            end
            bar_pkg::ST_FS_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_fs  = 1'b1;
                    state_next = bar_pkg::ST_CHECK;
                end
            end
            bar_pkg::ST_CHECK:
            begin
                if (stat.out_done)
                    state_next = bar_pkg::ST_FINISH;
                else
                begin
                    cmd.div_cen = 1'b1;
                    state_next  = bar_pkg::ST_CEN_WAIT;
                end
            end
            bar_pkg::ST_CEN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_cen = 1'b1;
                    state_next = bar_pkg::ST_BOUNDS;
                end
            end
            bar_pkg::ST_BOUNDS:
            begin
                if (stat.hi_late)
                    state_next = bar_pkg::ST_FINISH;
                else if (stat.limit)
                begin
                    // past the result limit: advance without producing
                    cmd.skip   = 1'b1;
                    state_next = bar_pkg::ST_CHECK;
                end
                else
                begin
                    cmd.open_out = 1'b1;
                    state_next   = bar_pkg::ST_TAP;
                end
            end
            bar_pkg::ST_TAP:
            begin
                if (stat.taps_left)
                begin
                    cmd.div_tap = 1'b1;
                    state_next  = bar_pkg::ST_TAP_WAIT;
                end
                else
                    state_next = bar_pkg::ST_NORM;
            end
            bar_pkg::ST_TAP_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_u   = 1'b1;
                    state_next = bar_pkg::ST_K1;
                end
            end
            bar_pkg::ST_K1: state_next = bar_pkg::ST_K2;
            bar_pkg::ST_K2: state_next = bar_pkg::ST_K3;
            bar_pkg::ST_K3: state_next = bar_pkg::ST_K4;
            bar_pkg::ST_K4: state_next = bar_pkg::ST_ACC;
            bar_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = bar_pkg::ST_TAP;
            end
            bar_pkg::ST_NORM:
            begin
                cmd.div_norm = 1'b1;
                state_next   = bar_pkg::ST_NORM_WAIT;
            end
            bar_pkg::ST_NORM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_chan = 1'b1;
                    state_next  = stat.last_chan ? bar_pkg::ST_EMIT : bar_pkg::ST_NORM;
                end
            end
            bar_pkg::ST_EMIT:
            begin
                // hold until the previous result can move to the output beat
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bar_pkg::ST_CHECK;
                end
            end
            bar_pkg::ST_FINISH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.wrap_up = 1'b1;
                    state_next  = bar_pkg::ST_IDLE;
                end
            end
            default: state_next = bar_pkg::ST_IDLE;
        endcase
    end

endmodule
